>>> rtl/qalu_pkg.sv
`timescale 1ns / 1ps

package qalu_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int DATA_W = 32;
   // Square magnitude before output clipping: four terms of at most 2^(62-F).
   localparam int DEN_W = 65 - FRACTION_BITS;
   // Dividend of a quotient: a 32 bit magnitude shifted up by the fraction.
   localparam int NUM_W = DATA_W + FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_CONJ  = 3'd3,
      OP_SCALE = 3'd4,
      OP_INV   = 3'd5,
      OP_DIV   = 3'd6,
      OP_NORM  = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] a_real;
      logic signed [31:0] a_i;
      logic signed [31:0] a_j;
      logic signed [31:0] a_k;
      logic signed [31:0] b_real;
      logic signed [31:0] b_i;
      logic signed [31:0] b_j;
      logic signed [31:0] b_k;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_real;
      logic signed [31:0] out_i;
      logic signed [31:0] out_j;
      logic signed [31:0] out_k;
      logic [31:0]        square_magnitude;
      logic               zero_divide;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic simple;
      logic ham;
      logic scale;
      logic inv;
      logic div;
      logic norm;
   } class_type;

   typedef struct packed {
      op_type           op;
      class_type        cls;
      logic [3:0][31:0] a;
      logic [3:0][31:0] b;
   } job_type;

   // Returns the saturation flag above the clipped 32 bit value.
   function automatic logic [32:0] clip32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7fffffff};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h80000000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

>>> rtl/qalu_front.sv
`timescale 1ns / 1ps

module qalu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qalu_pkg::req_type req_data,
   output logic              job_valid,
   output qalu_pkg::job_type job_data,
   input  logic              job_pop
);

   qalu_pkg::job_type                 queue_ff [qalu_pkg::QDEPTH];
   logic [qalu_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [qalu_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [qalu_pkg::QCNT_W-1:0]       count_ff, count_in;
   qalu_pkg::job_type                 job_new;
   logic                              push;
   logic                              pop;

   always_comb begin
      job_new.op = qalu_pkg::op_type'(req_data.operation);
      job_new.a = {req_data.a_k, req_data.a_j, req_data.a_i, req_data.a_real};
      job_new.b = {req_data.b_k, req_data.b_j, req_data.b_i, req_data.b_real};
      job_new.cls = '0;
      unique case (job_new.op)
         qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_CONJ: job_new.cls.simple = 1'b1;
         qalu_pkg::OP_MUL:   job_new.cls.ham = 1'b1;
         qalu_pkg::OP_SCALE: job_new.cls.scale = 1'b1;
         qalu_pkg::OP_INV:   job_new.cls.inv = 1'b1;
         qalu_pkg::OP_DIV:   job_new.cls.div = 1'b1;
         qalu_pkg::OP_NORM:  job_new.cls.norm = 1'b1;
         default:            job_new.cls.simple = 1'b1;
      endcase
   end

   assign req_stall = (count_ff == qalu_pkg::QCNT_W'(qalu_pkg::QDEPTH));
   assign push = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign pop = job_pop && job_valid;
   assign job_data = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/qalu_div.sv
`timescale 1ns / 1ps

module qalu_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [32:0]              num,
   input  logic [qalu_pkg::DEN_W-1:0]      den,
   output logic                            done,
   output logic [31:0]                     quo,
   output logic                            quo_sat
);

   logic [qalu_pkg::NUM_W-1:0] dvd_ff, dvd_in;
   logic [qalu_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [qalu_pkg::DEN_W-1:0] den_ff, den_in;
   logic [qalu_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       neg_ff, neg_in;
   logic                       done_ff, done_in;
   logic [32:0]                mag;
   logic [qalu_pkg::DEN_W:0]   trial;
   logic [qalu_pkg::DEN_W:0]   diff;

   assign mag = num[32] ? 33'(-num) : 33'(num);
   assign trial = {rem_ff, dvd_ff[qalu_pkg::NUM_W-1]};
   assign diff = trial - {1'b0, den_ff};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      if (start) begin
         // The magnitude never exceeds 2^31, so it fits the top 32 bits.
         dvd_in = {mag[31:0], {qalu_pkg::FRACTION_BITS{1'b0}}};
         rem_in = '0;
         den_in = den;
         neg_in = num[32];
         cnt_in = qalu_pkg::CNT_W'(qalu_pkg::NUM_W);
      end else if (cnt_ff != '0) begin
         // One restoring step: the quotient bit shifts in as the dividend shifts out.
         if (!diff[qalu_pkg::DEN_W]) begin
            rem_in = diff[qalu_pkg::DEN_W-1:0];
            dvd_in = {dvd_ff[qalu_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[qalu_pkg::DEN_W-1:0];
            dvd_in = {dvd_ff[qalu_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == qalu_pkg::CNT_W'(1));
      end
   end

   always_comb begin
      quo_sat = 1'b0;
      if (!neg_ff) begin
         if (dvd_ff > qalu_pkg::NUM_W'(32'h7fffffff)) begin
            quo_sat = 1'b1;
            quo = 32'h7fffffff;
         end else begin
            quo = dvd_ff[31:0];
         end
      end else begin
         if (dvd_ff > qalu_pkg::NUM_W'(33'h080000000)) begin
            quo_sat = 1'b1;
            quo = 32'h80000000;
         end else begin
            quo = 32'(-dvd_ff[31:0]);
         end
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
   end

endmodule

>>> rtl/qalu_back.sv
`timescale 1ns / 1ps

module qalu_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  qalu_pkg::job_type job_data,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qalu_pkg::rsp_type rsp_data
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_SQ   = 10'b0000000010,
      ST_SUM  = 10'b0000000100,
      ST_HMUL = 10'b0000001000,
      ST_HSUM = 10'b0000010000,
      ST_SMUL = 10'b0000100000,
      ST_SSUM = 10'b0001000000,
      ST_ROOT = 10'b0010000000,
      ST_DIV  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   localparam int F = qalu_pkg::FRACTION_BITS;

   state_type                        state_ff, state_in;
   qalu_pkg::op_type                 op_ff, op_in;
   qalu_pkg::class_type              cls_ff, cls_in;
   logic signed [31:0]               a_ff [4];
   logic signed [31:0]               a_in [4];
   logic signed [31:0]               b_ff [4];
   logic signed [31:0]               b_in [4];
   logic signed [31:0]               r_ff [4];
   logic signed [31:0]               r_in [4];
   logic signed [63:0]               prod_ff [4];
   logic signed [63:0]               prod_in [4];
   logic [qalu_pkg::DEN_W-1:0]       mag_a_ff, mag_a_in;
   logic [qalu_pkg::DEN_W-1:0]       den_ff, den_in;
   logic [63:0]                      rv_ff, rv_in;
   logic [63:0]                      rres_ff, rres_in;
   logic [4:0]                       rcnt_ff, rcnt_in;
   logic [1:0]                       idx_ff, idx_in;
   logic                             phase_b_ff, phase_b_in;
   logic                             div_run_ff, div_run_in;
   logic                             sat_ff, sat_in;
   logic                             zdiv_ff, zdiv_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   qalu_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             out_free;
   logic [65:0]                      mag_sum;
   logic [65:0]                      s_sum;
   logic [63:0]                      s_sat;
   logic signed [65:0]               ham_sum;
   logic [32:0]                      cl;
   logic [63:0]                      root_bit;
   logic [63:0]                      root_trial;
   logic                             div_start;
   logic signed [32:0]               div_num;
   logic                             div_done;
   logic [31:0]                      div_quo;
   logic                             div_sat;
   logic signed [31:0]               src;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Term n of Hamilton row idx pairs a[n] with b[idx ^ n]; these terms subtract.
   function automatic logic ham_neg(input logic [1:0] row, input logic [1:0] n);
      logic r;
      unique case (row)
         2'd0:    r = (n != 2'd0);
         2'd1:    r = (n == 2'd3);
         2'd2:    r = (n == 2'd1);
         default: r = (n == 2'd2);
      endcase
      return r;
   endfunction

   always_comb begin
      mag_sum = '0;
      s_sum = '0;
      ham_sum = '0;
      for (int n = 0; n < 4; n++) begin
         mag_sum = mag_sum + 66'(prod_ff[n][63:F]);
         s_sum = s_sum + 66'(unsigned'(prod_ff[n]));
         if (ham_neg(idx_ff, 2'(n))) begin
            ham_sum = ham_sum - 66'(prod_ff[n] >>> F);
         end else begin
            ham_sum = ham_sum + 66'(prod_ff[n] >>> F);
         end
      end
      s_sat = (s_sum[65:64] != 2'b00) ? '1 : s_sum[63:0];
   end

   assign root_bit = 64'd1 << (6'd62 - {rcnt_ff, 1'b0});
   assign root_trial = rres_ff + root_bit;

   always_comb begin
      src = (op_ff == qalu_pkg::OP_DIV) ? b_ff[idx_ff] : a_ff[idx_ff];
      if (op_ff == qalu_pkg::OP_NORM || idx_ff == 2'd0) begin
         div_num = 33'(src);
      end else begin
         div_num = -33'(src);
      end
   end

   assign div_start = (state_ff == ST_DIV) && !div_run_ff;

   qalu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (den_ff),
      .done    (div_done),
      .quo     (div_quo),
      .quo_sat (div_sat)
   );

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cls_in = cls_ff;
      a_in = a_ff;
      b_in = b_ff;
      r_in = r_ff;
      prod_in = prod_ff;
      mag_a_in = mag_a_ff;
      den_in = den_ff;
      rv_in = rv_ff;
      rres_in = rres_ff;
      rcnt_in = rcnt_ff;
      idx_in = idx_ff;
      phase_b_in = phase_b_ff;
      div_run_in = div_run_ff;
      sat_in = sat_ff;
      zdiv_in = zdiv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      job_pop = 1'b0;
      cl = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               op_in = job_data.op;
               cls_in = job_data.cls;
               for (int n = 0; n < 4; n++) begin
                  a_in[n] = job_data.a[n];
                  b_in[n] = job_data.b[n];
                  r_in[n] = '0;
               end
               phase_b_in = 1'b0;
               sat_in = 1'b0;
               zdiv_in = 1'b0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            for (int n = 0; n < 4; n++) begin
               if (phase_b_ff) begin
                  prod_in[n] = b_ff[n] * b_ff[n];
               end else begin
                  prod_in[n] = a_ff[n] * a_ff[n];
               end
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            idx_in = '0;
            if (phase_b_ff) begin
               if (mag_sum == '0) begin
                  zdiv_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  den_in = mag_sum[qalu_pkg::DEN_W-1:0];
                  state_in = ST_DIV;
               end
            end else begin
               mag_a_in = mag_sum[qalu_pkg::DEN_W-1:0];
               priority if (cls_ff.simple) begin
                  for (int n = 0; n < 4; n++) begin
                     if (op_ff == qalu_pkg::OP_ADD) begin
                        cl = qalu_pkg::clip32(66'(a_ff[n]) + 66'(b_ff[n]));
                     end else if (op_ff == qalu_pkg::OP_SUB) begin
                        cl = qalu_pkg::clip32(66'(a_ff[n]) - 66'(b_ff[n]));
                     end else if (n == 0) begin
                        cl = {1'b0, a_ff[n]};
                     end else begin
                        cl = qalu_pkg::clip32(-66'(a_ff[n]));
                     end
                     r_in[n] = cl[31:0];
                     sat_in = sat_in | cl[32];
                  end
                  state_in = ST_DONE;
               end else if (cls_ff.scale) begin
                  state_in = ST_SMUL;
               end else if (cls_ff.ham) begin
                  state_in = ST_HMUL;
               end else if (cls_ff.inv) begin
                  if (mag_sum == '0) begin
                     zdiv_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     den_in = mag_sum[qalu_pkg::DEN_W-1:0];
                     state_in = ST_DIV;
                  end
               end else if (cls_ff.div) begin
                  phase_b_in = 1'b1;
                  state_in = ST_SQ;
               end else begin
                  if (s_sat == '0) begin
                     zdiv_in = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     rv_in = s_sat;
                     rres_in = '0;
                     rcnt_in = '0;
                     state_in = ST_ROOT;
                  end
               end
            end
         end
         ST_HMUL: begin
            for (int n = 0; n < 4; n++) begin
               prod_in[n] = a_ff[n] * b_ff[idx_ff ^ 2'(n)];
            end
            state_in = ST_HSUM;
         end
         ST_HSUM: begin
            cl = qalu_pkg::clip32(ham_sum);
            r_in[idx_ff] = cl[31:0];
            sat_in = sat_ff | cl[32];
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff == 2'd3) ? ST_DONE : ST_HMUL;
         end
         ST_SMUL: begin
            for (int n = 0; n < 4; n++) begin
               prod_in[n] = a_ff[n] * b_ff[0];
            end
            state_in = ST_SSUM;
         end
         ST_SSUM: begin
            for (int n = 0; n < 4; n++) begin
               cl = qalu_pkg::clip32(66'(prod_ff[n] >>> F));
               r_in[n] = cl[31:0];
               sat_in = sat_in | cl[32];
            end
            state_in = ST_DONE;
         end
         ST_ROOT: begin
            if (rv_ff >= root_trial) begin
               rv_in = rv_ff - root_trial;
               rres_in = (rres_ff >> 1) + root_bit;
            end else begin
               rres_in = rres_ff >> 1;
            end
            rcnt_in = rcnt_ff + 1'b1;
            if (rcnt_ff == 5'd31) begin
               den_in = qalu_pkg::DEN_W'(rres_in);
               idx_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_start) begin
               div_run_in = 1'b1;
            end
            if (div_done) begin
               div_run_in = 1'b0;
               sat_in = sat_ff | div_sat;
               if (op_ff == qalu_pkg::OP_DIV) begin
                  b_in[idx_ff] = div_quo;
               end else begin
                  r_in[idx_ff] = div_quo;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 2'd3) begin
                  state_in = (op_ff == qalu_pkg::OP_DIV) ? ST_HMUL : ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.out_real = r_ff[0];
               rsp_in.out_i = r_ff[1];
               rsp_in.out_j = r_ff[2];
               rsp_in.out_k = r_ff[3];
               rsp_in.square_magnitude = (mag_a_ff > qalu_pkg::DEN_W'(32'hffffffff)) ?
                                         32'hffffffff : mag_a_ff[31:0];
               rsp_in.zero_divide = zdiv_ff;
               rsp_in.saturated = sat_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      cls_ff <= cls_in;
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
      prod_ff <= prod_in;
      mag_a_ff <= mag_a_in;
      den_ff <= den_in;
      rv_ff <= rv_in;
      rres_ff <= rres_in;
      rcnt_ff <= rcnt_in;
      idx_ff <= idx_in;
      phase_b_ff <= phase_b_in;
      sat_ff <= sat_in;
      zdiv_ff <= zdiv_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         div_run_ff <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/quaternion_alu.sv
// Multiply uses a product and a sum state per row; inverse runs the divider per term;
// normalise adds 32 square root steps; divide inverts b, then multiplies as above.
// Throughput: a four deep queue takes one word a cycle while not full; the back end
// finishes each word before it takes the next, with its shared bit-serial divider and square root.
// Reset (synchronous, active high) empties the queue and the output register.
`timescale 1ns / 1ps

module quaternion_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qalu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qalu_pkg::rsp_type rsp_data
);

   logic              job_valid;
   qalu_pkg::job_type job_data;
   logic              job_pop;

   qalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   qalu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
